// File: src/rhc_pkg.sv
// Types and constants shared by the RGB to HSV hue classifier.
`default_nettype none

package rhc_pkg;

    localparam int CHAN_W    = 8;
    localparam int HUE_W     = 12;
    localparam int SAT_W     = 10;
    localparam int VAL_W     = 10;
    localparam int REG_W     = 12;
    localparam int REG_IDX_W = 2;

    localparam int K_W        = CHAN_W + 1;
    localparam int NUM_W      = 20;
    localparam int DEN_W      = CHAN_W + 1;
    localparam int QUO_W      = 11;
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;

    localparam logic [HUE_W-1:0] HUE_TURN      = 12'd3600;
    localparam logic [HUE_W-1:0] HUE_OFF_RED   = 12'd3000;
    localparam logic [HUE_W-1:0] HUE_OFF_GREEN = 12'd600;
    localparam logic [HUE_W-1:0] HUE_OFF_BLUE  = 12'd1800;

    localparam logic [NUM_W-1:0] HUE_MUL   = 20'd1200;
    localparam logic [NUM_W-1:0] PCT_MUL   = 20'd2000;
    localparam logic [SAT_W-1:0] PCT_MAX   = 10'd1000;

    // Value is floor((1000 * mx + 127) / 255), taken as a multiply by 263173 over 2^26.
    localparam int VAL_PROD_W = 37;
    localparam int VAL_SHIFT  = 26;
    localparam logic [VAL_PROD_W-1:0] VAL_RCP_MUL = 37'd263173000;
    localparam logic [VAL_PROD_W-1:0] VAL_RCP_ADD = 37'd33422971;

    localparam logic [REG_IDX_W-1:0] REG_RED_UPPER    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ORANGE_UPPER = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_YELLOW_UPPER = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_GREEN_UPPER  = 2'd3;

    localparam logic [REG_W-1:0] RED_UPPER_RST    = 12'd200;
    localparam logic [REG_W-1:0] ORANGE_UPPER_RST = 12'd400;
    localparam logic [REG_W-1:0] YELLOW_UPPER_RST = 12'd630;
    localparam logic [REG_W-1:0] GREEN_UPPER_RST  = 12'd1550;

    typedef enum logic [2:0] {
        CLASS_RED    = 3'd0,
        CLASS_ORANGE = 3'd1,
        CLASS_YELLOW = 3'd2,
        CLASS_GREEN  = 3'd3,
        CLASS_NONE   = 3'd4
    } colour_class_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
    } div_lane_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue_base;
        logic [VAL_W-1:0] val;
        logic             grey;
        logic             black;
    } hue_side_t;

    typedef struct packed {
        div_lane_t hue_lane;
        div_lane_t sat_lane;
        hue_side_t side;
    } div_work_t;

endpackage

`default_nettype wire

// File: src/rhc_if.sv
// Stream interfaces for pixels in and HSV results out.
`default_nettype none

interface rhc_pixel_if
    import rhc_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface rhc_hsv_if
    import rhc_pkg::*;
    ();
    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [VAL_W-1:0] brightness;
    colour_class_t    colour_class;

    modport source (output valid, output hue, output saturation, output brightness,
                    output colour_class, input ready);
    modport sink (input valid, input hue, input saturation, input brightness,
                  input colour_class, output ready);
endinterface

`default_nettype wire

// File: src/rgb_to_hsv_hue_classifier.sv
// Pipelined RGB to HSV converter with programmable hue classifier.
//
//  Channel  Direction  Contents
//  pixel    in         red_in, green_in, blue_in (8 bits each)
//  hsv      out        hue, saturation, brightness, colour_class
//  cfg      in         cfg_we, cfg_index, cfg_data (four 12-bit hue bounds)
//
// One pixel enters per cycle while the pipeline is not stalled.
// The pipeline holds two restoring dividers for hue and saturation, cut into
// four stages of up to three quotient bits each, plus two stages before and two
// after them; value comes from a reciprocal multiply in the second stage.
// Reset clears the stage valid bits and loads the default hue bounds.
// Each stage holds its item while the next one is full and stalled, so a
// stall on the output fills bubbles first and loses nothing.
`default_nettype none

module rgb_to_hsv_hue_classifier
    import rhc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    rhc_pixel_if.sink                 pixel,
    rhc_hsv_if.source                 hsv,
    input  wire logic                 cfg_we,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [REG_W-1:0]     cfg_data
);

    localparam int ST_A   = 0;
    localparam int ST_B   = 1;
    localparam int ST_D0  = 2;
    localparam int ST_F   = ST_D0 + DIV_STAGES;
    localparam int ST_G   = ST_F + 1;
    localparam int NSTAGE = ST_G + 1;

    typedef struct packed {
        logic [K_W-1:0]    k;
        logic [CHAN_W-1:0] d;
        logic [CHAN_W-1:0] mx;
        logic [HUE_W-1:0]  hue_base;
    } stage_a_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [VAL_W-1:0] val;
    } stage_f_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [VAL_W-1:0] val;
        colour_class_t    cls;
    } stage_g_t;

    function automatic div_lane_t div_stage(div_lane_t l, int stage);
        div_lane_t        r;
        logic [NUM_W-1:0] sh;
        int               b;
        r = l;
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            b = QUO_W - 1 - stage * DIV_STEPS - j;
            if (b >= 0)
            begin
                sh = NUM_W'(r.den) << b;
                if (r.rem >= sh)
                begin
                    r.rem    = r.rem - sh;
                    r.quo[b] = 1'b1;
                end
            end
        end
        return r;
    endfunction

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] take;

    logic [REG_W-1:0] red_upper_reg;
    logic [REG_W-1:0] orange_upper_reg;
    logic [REG_W-1:0] yellow_upper_reg;
    logic [REG_W-1:0] green_upper_reg;

    stage_a_t  a_reg;
    stage_a_t  a_next;
    div_work_t b_reg;
    div_work_t b_next;
    div_work_t div_reg [DIV_STAGES];
    div_work_t div_src [DIV_STAGES];
    stage_f_t  f_reg;
    stage_f_t  f_next;
    stage_g_t  g_reg;
    stage_g_t  g_next;

    always_comb
    begin
        take[NSTAGE-1] = hsv.ready || !valid_reg[NSTAGE-1];
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            take[i] = take[i+1] || !valid_reg[i];
        end
        valid_next = valid_reg;
        if (take[0])
        begin
            valid_next[0] = pixel.valid;
        end
        for (int i = 1; i < NSTAGE; i++)
        begin
            if (take[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_upper_reg    <= RED_UPPER_RST;
            orange_upper_reg <= ORANGE_UPPER_RST;
            yellow_upper_reg <= YELLOW_UPPER_RST;
            green_upper_reg  <= GREEN_UPPER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RED_UPPER:    red_upper_reg    <= cfg_data;
                REG_ORANGE_UPPER: orange_upper_reg <= cfg_data;
                REG_YELLOW_UPPER: yellow_upper_reg <= cfg_data;
                REG_GREEN_UPPER:  green_upper_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // The hue is split as (base - 600) + round(600 * (d + p - q) / d), so the
    // dividend stays non-negative for every sector.
    always_comb
    begin
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] mn;
        r = pixel.red_in;
        g = pixel.green_in;
        b = pixel.blue_in;
        mn = r;
        if (g < mn)
        begin
            mn = g;
        end
        if (b < mn)
        begin
            mn = b;
        end
        if (r >= g && r >= b)
        begin
            a_next.mx       = r;
            a_next.hue_base = HUE_OFF_RED;
        end
        else if (g >= b)
        begin
            a_next.mx       = g;
            a_next.hue_base = HUE_OFF_GREEN;
        end
        else
        begin
            a_next.mx       = b;
            a_next.hue_base = HUE_OFF_BLUE;
        end
        a_next.d = a_next.mx - mn;
        if (r >= g && r >= b)
        begin
            a_next.k = K_W'(a_next.d) + K_W'(g) - K_W'(b);
        end
        else if (g >= b)
        begin
            a_next.k = K_W'(a_next.d) + K_W'(b) - K_W'(r);
        end
        else
        begin
            a_next.k = K_W'(a_next.d) + K_W'(r) - K_W'(g);
        end
    end

    always_comb
    begin
        b_next.hue_lane.rem = NUM_W'(a_reg.k) * HUE_MUL + NUM_W'(a_reg.d);
        b_next.hue_lane.den = {a_reg.d, 1'b0};
        b_next.hue_lane.quo = '0;
        b_next.sat_lane.rem = NUM_W'(a_reg.d) * PCT_MUL + NUM_W'(a_reg.mx);
        b_next.sat_lane.den = {a_reg.mx, 1'b0};
        b_next.sat_lane.quo = '0;
        b_next.side.hue_base = a_reg.hue_base;
        b_next.side.val      = VAL_W'((VAL_PROD_W'(a_reg.mx) * VAL_RCP_MUL + VAL_RCP_ADD)
                                      >> VAL_SHIFT);
        b_next.side.grey     = (a_reg.d == '0);
        b_next.side.black    = (a_reg.mx == '0);
    end

    always_ff @(posedge clk)
    begin
        if (take[ST_A])
        begin
            a_reg <= a_next;
        end
        if (take[ST_B])
        begin
            b_reg <= b_next;
        end
        if (take[ST_F])
        begin
            f_reg <= f_next;
        end
        if (take[ST_G])
        begin
            g_reg <= g_next;
        end
    end

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        if (s == 0)
        begin : g_first
            assign div_src[s] = b_reg;
        end
        else
        begin : g_next_stage
            assign div_src[s] = div_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (take[ST_D0+s])
            begin
                div_reg[s].hue_lane <= div_stage(div_src[s].hue_lane, s);
                div_reg[s].sat_lane <= div_stage(div_src[s].sat_lane, s);
                div_reg[s].side     <= div_src[s].side;
            end
        end
    end

    always_comb
    begin
        logic [HUE_W:0] sum;
        sum = {1'b0, div_reg[DIV_STAGES-1].side.hue_base}
            + (HUE_W + 1)'(div_reg[DIV_STAGES-1].hue_lane.quo);
        if (div_reg[DIV_STAGES-1].side.grey)
        begin
            f_next.hue = '0;
        end
        else if (sum >= {1'b0, HUE_TURN})
        begin
            f_next.hue = HUE_W'(sum - {1'b0, HUE_TURN});
        end
        else
        begin
            f_next.hue = HUE_W'(sum);
        end
        f_next.sat = div_reg[DIV_STAGES-1].side.black
                   ? '0 : SAT_W'(div_reg[DIV_STAGES-1].sat_lane.quo);
        f_next.val = div_reg[DIV_STAGES-1].side.val;
    end

    always_comb
    begin
        g_next.hue = f_reg.hue;
        g_next.sat = f_reg.sat;
        g_next.val = f_reg.val;
        if (f_reg.hue <= red_upper_reg)
        begin
            g_next.cls = CLASS_RED;
        end
        else if (f_reg.hue <= orange_upper_reg)
        begin
            g_next.cls = CLASS_ORANGE;
        end
        else if (f_reg.hue <= yellow_upper_reg)
        begin
            g_next.cls = CLASS_YELLOW;
        end
        else if (f_reg.hue <= green_upper_reg)
        begin
            g_next.cls = CLASS_GREEN;
        end
        else
        begin
            g_next.cls = CLASS_NONE;
        end
    end

    assign pixel.ready      = take[ST_A];
    assign hsv.valid        = valid_reg[ST_G];
    assign hsv.hue          = g_reg.hue;
    assign hsv.saturation   = g_reg.sat;
    assign hsv.brightness   = g_reg.val;
    assign hsv.colour_class = g_reg.cls;

    // The wrap stage must never leave a full turn or more in the hue.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ST_G] |-> (g_reg.hue < HUE_TURN))
        else $error("hue result out of range");

    // Saturation and value quotients stay within one thousand.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ST_G] |-> (g_reg.sat <= PCT_MAX && g_reg.val <= PCT_MAX))
        else $error("saturation or brightness out of range");

    // A pixel transfer always lands in the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && take[ST_A]) |=> valid_reg[ST_A])
        else $error("accepted pixel lost at pipeline entry");

    // A full stage F that cannot advance keeps its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[ST_F] && !take[ST_F]) |=> valid_reg[ST_F])
        else $error("stalled stage dropped its item");

endmodule

`default_nettype wire

// File: dv/rhc_hsv_checker.sv
// Checker that predicts each HSV result from the accepted pixel and compares it.
module rhc_hsv_checker
    import rhc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    rhc_pixel_if                 pixel,
    rhc_hsv_if                   hsv,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] saturation;
        logic [VAL_W-1:0] brightness;
        colour_class_t    colour_class;
    } hsv_result_t;

    localparam int PRINT_LIMIT = 40;

    hsv_result_t      hsv_expected [$];
    logic [REG_W-1:0] hue_bound [4];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic hsv_result_t hsv_of_pixel(input logic [CHAN_W-1:0] r_in,
                                                 input logic [CHAN_W-1:0] g_in,
                                                 input logic [CHAN_W-1:0] b_in);
        hsv_result_t res;
        int unsigned r, g, b, mx, mn, d, num, hue_t, sat_t, val_t;
        r = 32'(r_in);
        g = 32'(g_in);
        b = 32'(b_in);
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        if (d == 0)
        begin
            hue_t = 0;
        end
        else
        begin
            if (mx == r)
                num = 3600 * d + 600 * g - 600 * b;
            else if (mx == g)
                num = 1200 * d + 600 * b - 600 * r;
            else
                num = 2400 * d + 600 * r - 600 * g;
            hue_t = (2 * num + d) / (2 * d);
            while (hue_t >= 3600)
                hue_t -= 3600;
        end
        sat_t = (mx == 0) ? 0 : (2000 * d + mx) / (2 * mx);
        val_t = (2000 * mx + 255) / 510;
        res.hue        = hue_t[HUE_W-1:0];
        res.saturation = sat_t[SAT_W-1:0];
        res.brightness = val_t[VAL_W-1:0];
        if (hue_t <= 32'(hue_bound[REG_RED_UPPER]))
            res.colour_class = CLASS_RED;
        else if (hue_t <= 32'(hue_bound[REG_ORANGE_UPPER]))
            res.colour_class = CLASS_ORANGE;
        else if (hue_t <= 32'(hue_bound[REG_YELLOW_UPPER]))
            res.colour_class = CLASS_YELLOW;
        else if (hue_t <= 32'(hue_bound[REG_GREEN_UPPER]))
            res.colour_class = CLASS_GREEN;
        else
            res.colour_class = CLASS_NONE;
        return res;
    endfunction

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("[%0t] ERROR %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hsv_result_t want;
        if (!rst_n)
        begin
            hue_bound[REG_RED_UPPER]    = RED_UPPER_RST;
            hue_bound[REG_ORANGE_UPPER] = ORANGE_UPPER_RST;
            hue_bound[REG_YELLOW_UPPER] = YELLOW_UPPER_RST;
            hue_bound[REG_GREEN_UPPER]  = GREEN_UPPER_RST;
            hsv_expected.delete();
        end
        else
        begin
            if (cfg_we)
                hue_bound[cfg_index] = cfg_data;
            if (hsv.valid && hsv.ready)
            begin
                if (hsv_expected.size() == 0)
                begin
                    log_failure($sformatf("result with nothing outstanding: hue %0d sat %0d val %0d",
                                          hsv.hue, hsv.saturation, hsv.brightness));
                end
                else
                begin
                    want = hsv_expected.pop_front();
                    if (hsv.hue !== want.hue)
                        log_failure($sformatf("hue got %0d expected %0d", hsv.hue, want.hue));
                    if (hsv.saturation !== want.saturation)
                        log_failure($sformatf("saturation got %0d expected %0d",
                                              hsv.saturation, want.saturation));
                    if (hsv.brightness !== want.brightness)
                        log_failure($sformatf("brightness got %0d expected %0d",
                                              hsv.brightness, want.brightness));
                    if (hsv.colour_class !== want.colour_class)
                        log_failure($sformatf("colour_class got %0d expected %0d (hue %0d)",
                                              hsv.colour_class, want.colour_class, want.hue));
                end
            end
            if (pixel.valid && pixel.ready)
                hsv_expected.push_back(hsv_of_pixel(pixel.red_in, pixel.green_in, pixel.blue_in));
        end
        pending = hsv_expected.size();
    end

endmodule

// File: dv/tb_top.sv
// Top of the hue classifier testbench: clock, reset, pixel stimulus, bounds and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rhc_pkg::*;

    localparam int DRAIN_CYCLES = 16;
    localparam int IDLE_LIMIT   = 3000;
    localparam int LONG_HOLD    = 300;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending;
    int                   burst_left;
    int                   idle_cycles = 0;
    bit                   long_hold_pending;

    rhc_pixel_if pixel_ch ();
    rhc_hsv_if   hsv_ch ();

    rgb_to_hsv_hue_classifier u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel_ch),
        .hsv       (hsv_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rhc_hsv_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (pixel_ch),
        .hsv        (hsv_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b);
        if (burst_left == 0)
        begin
            pixel_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : int'($urandom_range(1, 8));
        end
        pixel_ch.valid    <= 1'b1;
        pixel_ch.red_in   <= r;
        pixel_ch.green_in <= g;
        pixel_ch.blue_in  <= b;
        @(posedge clk);
        while (!pixel_ch.ready)
            @(posedge clk);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic random_pixel();
        logic [CHAN_W-1:0] c, lo_v;
        int mode;
        mode = $urandom_range(0, 9);
        c    = CHAN_W'($urandom_range(0, 255));
        lo_v = CHAN_W'($urandom_range(0, 255));
        case (mode)
            4, 5:
            begin
                case ($urandom_range(0, 5))
                    0: send_pixel(8'd255, c, 8'd0);
                    1: send_pixel(8'd255, 8'd0, c);
                    2: send_pixel(c, 8'd255, 8'd0);
                    3: send_pixel(8'd0, 8'd255, c);
                    4: send_pixel(c, 8'd0, 8'd255);
                    default: send_pixel(8'd0, c, 8'd255);
                endcase
            end
            6: send_pixel(c, c, c);
            7: send_pixel(CHAN_W'($urandom_range(0, 3)), CHAN_W'($urandom_range(0, 3)),
                          CHAN_W'($urandom_range(0, 3)));
            8:
            begin
                case ($urandom_range(0, 2))
                    0: send_pixel(c, c, lo_v);
                    1: send_pixel(c, lo_v, c);
                    default: send_pixel(lo_v, c, c);
                endcase
            end
            9: send_pixel(CHAN_W'($urandom_range(250, 255)), CHAN_W'($urandom_range(250, 255)),
                          CHAN_W'($urandom_range(250, 255)));
            default: send_pixel(CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
                                CHAN_W'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic random_run(input int count);
        repeat (count)
            random_pixel();
    endtask

    task automatic wait_idle();
        pixel_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_bounds(input logic [REG_W-1:0] red, input logic [REG_W-1:0] orange,
                                input logic [REG_W-1:0] yellow, input logic [REG_W-1:0] green);
        cfg_we    <= 1'b1;
        cfg_index <= REG_RED_UPPER;
        cfg_data  <= red;
        @(negedge clk);
        cfg_index <= REG_ORANGE_UPPER;
        cfg_data  <= orange;
        @(negedge clk);
        cfg_index <= REG_YELLOW_UPPER;
        cfg_data  <= yellow;
        @(negedge clk);
        cfg_index <= REG_GREEN_UPPER;
        cfg_data  <= green;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // The receiver runs its own stall pattern and honors one long hold-off on request.
    initial
    begin
        int  seg;
        int  mode;
        bit  toggle;
        hsv_ch.ready = 1'b0;
        toggle = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(8, 64);
            repeat (seg)
            begin
                @(negedge clk);
                if (long_hold_pending)
                begin
                    long_hold_pending = 1'b0;
                    hsv_ch.ready <= 1'b0;
                    repeat (LONG_HOLD) @(negedge clk);
                end
                toggle = !toggle;
                case (mode)
                    0: hsv_ch.ready <= 1'b1;
                    1: hsv_ch.ready <= 1'($urandom_range(0, 1));
                    2: hsv_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: hsv_ch.ready <= toggle;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pixel_ch.valid && pixel_ch.ready) || (hsv_ch.valid && hsv_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("rgb_to_hsv_hue_classifier regression: fail");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int bnd [4];
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_RED_UPPER;
        cfg_data          = '0;
        pixel_ch.valid    = 1'b0;
        pixel_ch.red_in   = '0;
        pixel_ch.green_in = '0;
        pixel_ch.blue_in  = '0;
        burst_left        = 0;
        long_hold_pending = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd85, 8'd0);
        send_pixel(8'd255, 8'd86, 8'd0);
        send_pixel(8'd255, 8'd170, 8'd0);
        send_pixel(8'd255, 8'd128, 8'd0);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd1, 8'd1, 8'd0);
        send_pixel(8'd254, 8'd1, 8'd127);
        send_pixel(8'd100, 8'd200, 8'd50);
        send_pixel(8'd10, 8'd20, 8'd200);
        random_run(120);

        wait_idle();
        write_bounds(12'd0, 12'd0, 12'd0, 12'd0);
        random_run(60);

        wait_idle();
        write_bounds(12'd4095, 12'd4095, 12'd4095, 12'd4095);
        random_run(50);

        wait_idle();
        write_bounds(12'd3000, 12'd1000, 12'd2000, 12'd3599);
        long_hold_pending = 1'b1;
        random_run(80);

        wait_idle();
        foreach (bnd[i])
            bnd[i] = $urandom_range(0, 3599);
        bnd.sort();
        write_bounds(REG_W'(bnd[0]), REG_W'(bnd[1]), REG_W'(bnd[2]), REG_W'(bnd[3]));
        random_run(80);

        wait_idle();
        write_bounds(REG_W'($urandom_range(0, 4095)), REG_W'($urandom_range(0, 4095)),
                     REG_W'($urandom_range(0, 4095)), REG_W'($urandom_range(0, 4095)));
        random_run(60);

        wait_idle();
        write_bounds(12'd1, 12'd1799, 12'd1800, 12'd3599);
        random_run(80);

        wait_idle();
        if (fail_count == 0)
            $display("rgb_to_hsv_hue_classifier regression: pass");
        else
            $display("rgb_to_hsv_hue_classifier regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
src/rhc_pkg.sv
src/rhc_if.sv
src/rgb_to_hsv_hue_classifier.sv
dv/rhc_hsv_checker.sv
dv/tb_top.sv
